@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;

   localparam int OPCODE_W     = 2;
   localparam int DATA_W       = 8;
   localparam int CELL_INDEX_W = 11;
   localparam int CURSOR_POS_W = 11;

   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 32;

   localparam logic [DATA_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [DATA_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [DATA_W-1:0] ATTR_DEFAULT = 8'h07;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_ATTR  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // One classified command as it sits in the queue between front and back.
   typedef struct packed {
      op_type                  op;
      logic [DATA_W-1:0]       data;
      logic [CELL_INDEX_W-1:0] index;
      logic                    newline;
      logic                    in_range;
   } cmd_type;

endpackage

@@ hw/rtl/tcw_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tcw_front.sv @@
// Front end: accepts request transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: data_byte [7:0], cell_index [18:8], zero [23:19]
   input  logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: opcode [1:0]
   input  logic [tcw_pkg::OPCODE_W-1:0]     req_tuser,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output tcw_pkg::cmd_type                 cmd
);

   localparam int CellCount = COLUMNS * ROWS;
   localparam int DataW     = tcw_pkg::DATA_W;
   localparam int IndexW    = tcw_pkg::CELL_INDEX_W;

   tcw_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;
   tcw_pkg::cmd_type cmd_new;

   // Decode the transaction into a queue entry.
   always_comb begin
      cmd_new.op       = tcw_pkg::op_type'(req_tuser);
      cmd_new.data     = req_tdata[DataW-1:0];
      cmd_new.index    = req_tdata[DataW+IndexW-1:DataW];
      cmd_new.newline  = (req_tdata[DataW-1:0] == tcw_pkg::CHAR_NEWLINE);
      cmd_new.in_range = (32'(req_tdata[DataW+IndexW-1:DataW]) < CellCount);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ hw/rtl/tcw_back.sv @@
// Back end: executes queued commands against the screen store and drives the response channel.
`timescale 1ns / 1ps

module tcw_back #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  tcw_pkg::cmd_type                cmd,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: cursor_pos [10:0], cell_char [18:11], cell_attr [26:19], scrolled [27],
   //            zero [31:28]
   output logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CellCount = COLUMNS * ROWS;
   localparam int AddrW     = $clog2(CellCount);
   localparam int CntW      = $clog2(CellCount + 1);
   localparam int ColW      = $clog2(COLUMNS);
   localparam int DataW     = tcw_pkg::DATA_W;
   localparam int PosW      = tcw_pkg::CURSOR_POS_W;
   localparam int RspW      = tcw_pkg::RSP_TDATA_W;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SW_INIT,
      SW_CLEAR,
      SW_SCROLL
   } sweep_type;

   state_type        state_ff, state_in;
   sweep_type        sweep_kind_ff, sweep_kind_in;
   logic [AddrW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [AddrW-1:0] sweep_last_ff, sweep_last_in;
   logic [CntW-1:0]  cursor_ff, cursor_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [DataW-1:0] attr_ff, attr_in;
   logic [AddrW-1:0] top_base_ff, top_base_in;
   logic             scr_ff, scr_in;
   logic             rd_sel_ff, rd_sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]  rsp_data_ff, rsp_data_in;

   logic             slot_free;
   logic             rsp_load;
   logic [AddrW:0]   cur_sum, idx_sum, top_sum;
   logic [AddrW-1:0] cur_phys, idx_phys, top_next;
   logic [CntW-1:0]  cursor_put;
   logic [ColW-1:0]  col_put;

   logic             we_char, we_attr, rd_en;
   logic [AddrW-1:0] wr_addr;
   logic [DataW-1:0] wr_char, wr_attr;
   logic [DataW-1:0] rd_char, rd_attr;
   logic [DataW-1:0] out_char, out_attr;

   // The store is a ring of rows: physical = (logical + top_base) mod cell count.
   assign cur_sum  = (AddrW+1)'(cursor_ff) + (AddrW+1)'(top_base_ff);
   assign cur_phys = (cur_sum >= (AddrW+1)'(CellCount))
                   ? AddrW'(cur_sum - (AddrW+1)'(CellCount)) : AddrW'(cur_sum);
   assign idx_sum  = (AddrW+1)'(cmd.index) + (AddrW+1)'(top_base_ff);
   assign idx_phys = (idx_sum >= (AddrW+1)'(CellCount))
                   ? AddrW'(idx_sum - (AddrW+1)'(CellCount)) : AddrW'(idx_sum);
   assign top_sum  = (AddrW+1)'(top_base_ff) + (AddrW+1)'(COLUMNS);
   assign top_next = (top_sum >= (AddrW+1)'(CellCount)) ? '0 : AddrW'(top_sum);

   // Newline jumps to the next row start, anything else steps one cell.
   assign cursor_put = cmd.newline ? cursor_ff + CntW'(COLUMNS) - CntW'(col_ff)
                                   : cursor_ff + CntW'(1);
   assign col_put    = (cmd.newline || col_ff == ColW'(COLUMNS - 1)) ? '0 : col_ff + ColW'(1);

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = (state_ff == ST_RESP) && slot_free;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign out_char  = rd_sel_ff ? rd_char : '0;
   assign out_attr  = rd_sel_ff ? rd_attr : '0;

   always_comb begin
      state_in      = state_ff;
      sweep_kind_in = sweep_kind_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      attr_in       = attr_ff;
      top_base_in   = top_base_ff;
      scr_in        = scr_ff;
      rd_sel_in     = rd_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      we_char       = 1'b0;
      we_attr       = 1'b0;
      wr_addr       = cur_phys;
      wr_char       = cmd.data;
      wr_attr       = attr_ff;
      rd_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               scr_in    = 1'b0;
               rd_sel_in = 1'b0;
               state_in  = ST_RESP;
               case (cmd.op)
                  tcw_pkg::OP_PUT: begin
                     we_char   = !cmd.newline;
                     we_attr   = !cmd.newline;
                     cursor_in = cursor_put;
                     col_in    = col_put;
                     // Past the last cell: blank the old top row, then advance the ring.
                     if (cursor_put >= CntW'(CellCount)) begin
                        state_in      = ST_SWEEP;
                        sweep_kind_in = SW_SCROLL;
                        sweep_addr_in = top_base_ff;
                        sweep_last_in = top_base_ff + AddrW'(COLUMNS - 1);
                     end
                  end
                  tcw_pkg::OP_ATTR: begin
                     attr_in = cmd.data;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cursor_in     = '0;
                     col_in        = '0;
                     state_in      = ST_SWEEP;
                     sweep_kind_in = SW_CLEAR;
                     sweep_addr_in = '0;
                     sweep_last_in = AddrW'(CellCount - 1);
                  end
                  tcw_pkg::OP_READ: begin
                     rd_en     = cmd.in_range;
                     rd_sel_in = cmd.in_range;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            we_char       = 1'b1;
            we_attr       = (sweep_kind_ff != SW_CLEAR);
            wr_addr       = sweep_addr_ff;
            wr_char       = tcw_pkg::CHAR_SPACE;
            wr_attr       = tcw_pkg::ATTR_DEFAULT;
            sweep_addr_in = sweep_addr_ff + AddrW'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               case (sweep_kind_ff)
                  SW_INIT: begin
                     state_in = ST_IDLE;
                  end
                  SW_SCROLL: begin
                     top_base_in = top_next;
                     cursor_in   = cursor_ff - CntW'(COLUMNS);
                     scr_in      = 1'b1;
                     state_in    = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RspW'({scr_ff, out_attr, out_char, PosW'(cursor_ff)});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_kind_ff <= SW_INIT;
         sweep_addr_ff <= '0;
         sweep_last_ff <= AddrW'(CellCount - 1);
         cursor_ff     <= '0;
         col_ff        <= '0;
         attr_ff       <= tcw_pkg::ATTR_DEFAULT;
         top_base_ff   <= '0;
         scr_ff        <= 1'b0;
         rd_sel_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_kind_ff <= sweep_kind_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         attr_ff       <= attr_in;
         top_base_ff   <= top_base_in;
         scr_ff        <= scr_in;
         rd_sel_ff     <= rd_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tcw_ram #(
      .WIDTH(DataW),
      .DEPTH(CellCount)
   ) u_char_ram (
      .clock  (clock),
      .wr_en  (we_char),
      .wr_addr(wr_addr),
      .wr_data(wr_char),
      .rd_en  (rd_en),
      .rd_addr(idx_phys),
      .rd_data(rd_char)
   );

   tcw_ram #(
      .WIDTH(DataW),
      .DEPTH(CellCount)
   ) u_attr_ram (
      .clock  (clock),
      .wr_en  (we_attr),
      .wr_addr(wr_addr),
      .wr_data(wr_attr),
      .rd_en  (rd_en),
      .rd_addr(idx_phys),
      .rd_data(rd_attr)
   );

   // Between commands the cursor is always on the screen and its column agrees.
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cursor_ff < CntW'(CellCount))
      else $error("cursor beyond last cell while idle");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (ColW+1)'(col_ff) < (ColW+1)'(COLUMNS))
      else $error("column beyond row width while idle");

   a_top_base_range: assert property (@(posedge clock) disable iff (reset)
      (AddrW+1)'(top_base_ff) < (AddrW+1)'(CellCount))
      else $error("top row base outside screen store");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      we_char |-> (AddrW+1)'(wr_addr) < (AddrW+1)'(CellCount))
      else $error("screen store write beyond last cell");

endmodule

@@ hw/rtl/text_console_writer_top.sv @@
// Top level of the text console writer: request queue front end and screen back end.
//
// Usage: each request transaction carries one command (req_tuser: 0 put character,
// 1 set attribute, 2 clear screen, 3 read cell) with its character/attribute byte and
// cell index in req_tdata. Every command yields exactly one response transaction with
// the cursor after the command, the character and attribute of a read cell (zero
// otherwise) and a flag set when the screen scrolled one row.
// Sequence: the back end executes an accepted command, then enters its respond step and
// registers the response; it takes the next command only after that response is loaded.
// A put that scrolls then blanks the new bottom row in a sweep; a clear sweeps all
// COLUMNS*ROWS cells, one cell per cycle through the character store write port.
// A two-entry queue takes requests while the back end is busy or waiting.
// Reset: after reset the back end blanks all COLUMNS*ROWS cells, one per cycle, before
// it executes the first command; the queue may already take two requests meanwhile.
// Stall: a response held by rsp_tready keeps the back end from issuing the next one;
// once the queue is full, req_tready drops.
`timescale 1ns / 1ps

module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: data_byte [7:0], cell_index [18:8], zero [23:19]
   input  logic [tcw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: opcode [1:0]
   input  logic [tcw_pkg::OPCODE_W-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: cursor_pos [10:0], cell_char [18:11], cell_attr [26:19], scrolled [27],
   //            zero [31:28]
   output logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic             cmd_valid;
   logic             cmd_ready;
   tcw_pkg::cmd_type cmd;

   tcw_front #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   tcw_back #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ verif/tb_text_console_writer_top.sv @@
// Testbench for text_console_writer_top: stream stimulus, a cell-level screen predictor and response checks.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
   import tcw_pkg::*;

   localparam int          COLS         = COLUMNS_DEF;
   localparam int          ROWS         = ROWS_DEF;
   localparam int          CELLS        = COLS * ROWS;
   localparam int          RANDOM_ITEMS = 450;
   localparam int          TAIL_CYCLES  = 20;
   localparam int unsigned LIMIT_CYCLES = 4_000_000;
   localparam logic [15:0] BLANK_CELL   = {ATTR_DEFAULT, CHAR_SPACE};

   typedef struct {
      op_type                  op;
      logic [DATA_W-1:0]       data;
      logic [CELL_INDEX_W-1:0] index;
      bit                      drain;
   } console_cmd_t;

   // Same bit order as rsp_tdata[27:0].
   typedef struct packed {
      logic                    scrolled;
      logic [7:0]              cell_attr;
      logic [7:0]              cell_char;
      logic [CURSOR_POS_W-1:0] cursor_pos;
   } console_reply_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // predicted screen state
   logic [15:0]       screen_model [CELLS];
   int unsigned       cursor_now;
   int unsigned       top_row_now;
   logic [DATA_W-1:0] attr_now;

   console_cmd_t   queued_commands [$];
   console_reply_t predicted_replies [$];
   console_cmd_t   next_cmd;
   console_reply_t want;
   console_reply_t got;

   int unsigned cycle_count = 0;
   int unsigned reply_count = 0;
   int unsigned mismatches  = 0;
   int unsigned send_gap    = 0;
   int unsigned recv_stall  = 0;
   bit          calm        = 1'b0;
   bit          req_taken   = 1'b0;

   text_console_writer_top #(
      .COLUMNS (COLS),
      .ROWS    (ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned screen_slot(int unsigned pos);
      return ((top_row_now + pos / COLS) % ROWS) * COLS + pos % COLS;
   endfunction

   // Apply one command to the screen state and return the reply it produces.
   function automatic console_reply_t apply_console_command(op_type op, logic [7:0] data,
                                                            logic [10:0] index);
      console_reply_t r;
      r = '0;
      case (op)
         OP_PUT: begin
            if (data == CHAR_NEWLINE) begin
               cursor_now = (cursor_now / COLS + 1) * COLS;
            end else begin
               screen_model[screen_slot(cursor_now)] = {attr_now, data};
               cursor_now++;
            end
            // scroll: blank the old top row, which becomes the new bottom one
            if (cursor_now >= CELLS) begin
               for (int c = 0; c < COLS; c++)
                  screen_model[top_row_now * COLS + c] = BLANK_CELL;
               top_row_now = (top_row_now + 1) % ROWS;
               cursor_now  = cursor_now - COLS;
               r.scrolled  = 1'b1;
            end
         end
         OP_ATTR: attr_now = data;
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_model[i][7:0] = CHAR_SPACE;
            cursor_now = 0;
         end
         default: begin
            if (index < CELLS) begin
               r.cell_char = screen_model[screen_slot(index)][7:0];
               r.cell_attr = screen_model[screen_slot(index)][15:8];
            end
         end
      endcase
      r.cursor_pos = cursor_now[CURSOR_POS_W-1:0];
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic note_mismatch(string what, int unsigned exp_val, int unsigned act_val);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch, %s at response %0d: expected 0x%0h, got 0x%0h",
                  what, reply_count, exp_val, act_val);
   endtask

   task automatic push_cmd(op_type op, logic [7:0] data, logic [10:0] index, bit drain);
      console_cmd_t c;
      c.op    = op;
      c.data  = data;
      c.index = index;
      c.drain = drain;
      queued_commands.push_back(c);
   endtask

   // Monitor: check the response first, then predict the request taken at this edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 300 == 0)
         calm = ($urandom_range(0, 3) == 0);
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[27:0];
            if (predicted_replies.size() == 0) begin
               note_mismatch("response with nothing pending", 0, rsp_tdata);
            end else begin
               want = predicted_replies.pop_front();
               if (got.cursor_pos != want.cursor_pos)
                  note_mismatch("cursor_pos", want.cursor_pos, got.cursor_pos);
               if (got.cell_char != want.cell_char)
                  note_mismatch("cell_char", want.cell_char, got.cell_char);
               if (got.cell_attr != want.cell_attr)
                  note_mismatch("cell_attr", want.cell_attr, got.cell_attr);
               if (got.scrolled != want.scrolled)
                  note_mismatch("scrolled", want.scrolled, got.scrolled);
               if (rsp_tdata[31:28] != '0)
                  note_mismatch("padding", 0, rsp_tdata[31:28]);
            end
            reply_count++;
         end
         if (req_taken)
            predicted_replies.push_back(apply_console_command(op_type'(req_tuser),
                                                              req_tdata[7:0],
                                                              req_tdata[18:8]));
      end
   end

   // Driver: hold a transaction until taken, then idle for the gap picked with it.
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (queued_commands.size() != 0 &&
                      !(queued_commands[0].drain && predicted_replies.size() != 0)) begin
            next_cmd = queued_commands.pop_front();
            req_tuser  <= next_cmd.op;
            req_tdata  <= {5'b0, next_cmd.index, next_cmd.data};
            req_tvalid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_stall = pick_gap();
      end
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned directed_len;
      int unsigned kind;
      int unsigned run_len;
      int unsigned roll;
      bit          hold;
      logic [7:0]  ch;
      logic [10:0] index;

      for (int i = 0; i < CELLS; i++)
         screen_model[i] = BLANK_CELL;
      cursor_now  = 0;
      top_row_now = 0;
      attr_now    = ATTR_DEFAULT;

      // reset contents, last cell, out-of-range reads
      push_cmd(OP_READ, 8'h00, 11'd0, 1'b0);
      push_cmd(OP_READ, 8'hFF, 11'(CELLS - 1), 1'b0);
      push_cmd(OP_READ, 8'h00, 11'(CELLS), 1'b0);
      push_cmd(OP_READ, 8'h00, 11'h7FF, 1'b0);
      // extreme bytes and attributes, newline mid-row
      push_cmd(OP_ATTR, 8'h00, 11'd0, 1'b0);
      push_cmd(OP_PUT, 8'h00, 11'h7FF, 1'b0);
      push_cmd(OP_ATTR, 8'hFF, 11'd0, 1'b0);
      push_cmd(OP_PUT, 8'hFF, 11'd0, 1'b0);
      push_cmd(OP_PUT, CHAR_NEWLINE, 11'd0, 1'b0);
      push_cmd(OP_PUT, 8'h41, 11'd0, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'd0, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'd1, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'(COLS), 1'b0);
      // clear keeps attributes, then newline from column zero
      push_cmd(OP_CLEAR, 8'hFF, 11'h7FF, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'd1, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'(COLS), 1'b0);
      push_cmd(OP_PUT, CHAR_NEWLINE, 11'd0, 1'b0);
      push_cmd(OP_ATTR, 8'h5A, 11'd0, 1'b0);
      push_cmd(OP_PUT, 8'h7E, 11'd0, 1'b0);
      push_cmd(OP_READ, 8'h00, 11'(COLS), 1'b0);
      push_cmd(OP_READ, 8'h00, 11'(COLS + 1), 1'b0);
      directed_len = queued_commands.size();

      // random part: text runs, newline bursts that drive the screen into scrolling, attributes, clears, reads
      while (queued_commands.size() < directed_len + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         hold = (queued_commands.size() == directed_len) || ($urandom_range(0, 49) == 0);
         if (kind < 45) begin
            run_len = $urandom_range(5, 40);
            for (int k = 0; k < run_len; k++) begin
               ch = ($urandom_range(0, 7) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
               push_cmd(OP_PUT, ch, 11'($urandom_range(0, 2047)), hold && k == 0);
            end
         end else if (kind < 55) begin
            run_len = $urandom_range(10, 30);
            for (int k = 0; k < run_len; k++)
               push_cmd(OP_PUT, CHAR_NEWLINE, 11'($urandom_range(0, 2047)), hold && k == 0);
         end else if (kind < 65) begin
            push_cmd(OP_ATTR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)), hold);
         end else if (kind < 68) begin
            push_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)), hold);
         end else begin
            run_len = $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
               roll = $urandom_range(0, 9);
               if (roll < 5)
                  index = 11'($urandom_range(0, CELLS - 1));
               else if (roll < 7)
                  index = 11'($urandom_range(0, 2 * COLS - 1));
               else if (roll < 9)
                  index = 11'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
               else
                  index = 11'($urandom_range(CELLS, 2047));
               push_cmd(OP_READ, 8'($urandom_range(0, 255)), index, hold && k == 0);
            end
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_commands.size() != 0 || req_tvalid)
         @(negedge clock);
      while (predicted_replies.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (predicted_replies.size() != 0)
         note_mismatch("responses never delivered", 0, predicted_replies.size());
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ text_console_writer_top.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
verif/tb_text_console_writer_top.sv
